### src/c8alu_pkg.sv
// Shared types, operation codes and status flag positions for the 8-bit ALU core.
package c8alu_pkg;

    localparam int unsigned CmdW  = 4;
    localparam int unsigned ByteW = 8;

    localparam logic [CmdW-1:0] CMD_OR   = 4'd0;
    localparam logic [CmdW-1:0] CMD_AND  = 4'd1;
    localparam logic [CmdW-1:0] CMD_XOR  = 4'd2;
    localparam logic [CmdW-1:0] CMD_ADD  = 4'd3;
    localparam logic [CmdW-1:0] CMD_SUB  = 4'd4;
    localparam logic [CmdW-1:0] CMD_CMP  = 4'd5;
    localparam logic [CmdW-1:0] CMD_BIT  = 4'd6;
    localparam logic [CmdW-1:0] CMD_SHL  = 4'd7;
    localparam logic [CmdW-1:0] CMD_ROL  = 4'd8;
    localparam logic [CmdW-1:0] CMD_SHR  = 4'd9;
    localparam logic [CmdW-1:0] CMD_ROR  = 4'd10;
    localparam logic [CmdW-1:0] CMD_INC  = 4'd11;
    localparam logic [CmdW-1:0] CMD_DEC  = 4'd12;
    localparam logic [CmdW-1:0] CMD_LOAD = 4'd13;

    localparam int unsigned FL_C = 0;
    localparam int unsigned FL_Z = 1;
    localparam int unsigned FL_D = 3;
    localparam int unsigned FL_V = 6;
    localparam int unsigned FL_N = 7;

    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 24;

    typedef struct packed {
        logic [CmdW-1:0]  cmd;
        logic [ByteW-1:0] operand_a;
        logic [ByteW-1:0] operand_b;
        logic [ByteW-1:0] status_in;
    } alu_req_t;

    typedef struct packed {
        logic [ByteW-1:0] result;
        logic [ByteW-1:0] status_out;
        logic             writes_result;
    } alu_res_t;

endpackage

### src/c8alu_exec.sv
// Combinational ALU: logic, binary/decimal add and subtract, compare, bit test, shifts.
module c8alu_exec (
    input  c8alu_pkg::alu_req_t req,
    output c8alu_pkg::alu_res_t res
);
    import c8alu_pkg::*;

    logic [ByteW-1:0] a, b, p, r;
    logic             cin, brw, wr;
    logic [ByteW:0]   sum, diff, cmp;
    logic [5:0]       dlo, dhi;
    logic             dlo_c;
    logic [ByteW-1:0] slo, shi;
    logic [ByteW-1:0] or_v, and_v, xor_v;

    always_comb begin
        a     = req.operand_a;
        b     = req.operand_b;
        cin   = req.status_in[FL_C];
        brw   = ~cin;
        or_v  = a | b;
        and_v = a & b;
        xor_v = a ^ b;
        sum   = {1'b0, a} + {1'b0, b} + {8'd0, cin};
        diff  = {1'b0, a} - {1'b0, b} - {8'd0, brw};
        cmp   = {1'b0, a} - {1'b0, b};

        // decimal add digits
        dlo = {2'b00, a[3:0]} + {2'b00, b[3:0]} + {5'd0, cin};
        if (dlo > 6'd9) begin
            dlo = dlo + 6'd6;
        end
        dlo_c = (dlo > 6'd15);
        dhi   = {2'b00, a[7:4]} + {2'b00, b[7:4]} + {5'd0, dlo_c};

        // decimal subtract digits
        slo = {4'd0, a[3:0]} - {4'd0, b[3:0]} - {7'd0, brw};
        if (slo[7]) begin
            slo = slo - 8'd6;
        end
        shi = {4'd0, a[7:4]} - {4'd0, b[7:4]} - {7'd0, slo[7]};
        if (shi[7]) begin
            shi = shi - 8'd6;
        end

        p  = req.status_in;
        r  = '0;
        wr = 1'b1;
        unique case (req.cmd)
            CMD_OR:   r = or_v;
            CMD_AND:  r = and_v;
            CMD_XOR:  r = xor_v;
            CMD_ADD: begin
                if (req.status_in[FL_D]) begin
                    p[FL_Z] = (sum[7:0] == 8'd0);
                    p[FL_N] = (sum[7:0] != 8'd0) && dhi[3];
                    p[FL_V] = ~(a[7] ^ b[7]) & (a[7] ^ dhi[3]);
                    r[3:0]  = dlo[3:0];
                    if (dhi > 6'd9) begin
                        dhi = dhi + 6'd6;
                    end
                    p[FL_C] = (dhi > 6'd15);
                    r[7:4]  = dhi[3:0];
                end else begin
                    r       = sum[7:0];
                    p[FL_V] = ~(a[7] ^ b[7]) & (a[7] ^ sum[7]);
                    p[FL_C] = sum[8];
                end
            end
            CMD_SUB: begin
                p[FL_V] = (a[7] ^ b[7]) & (a[7] ^ diff[7]);
                p[FL_C] = ~diff[8];
                if (req.status_in[FL_D]) begin
                    r = {shi[3:0], slo[3:0]};
                end else begin
                    r = diff[7:0];
                end
            end
            CMD_CMP: begin
                p[FL_C] = ~cmp[8];
                wr      = 1'b0;
            end
            CMD_BIT: begin
                p[FL_Z] = (and_v == 8'd0);
                p[FL_N] = b[7];
                p[FL_V] = b[6];
                wr      = 1'b0;
            end
            CMD_SHL: begin
                r       = {b[6:0], 1'b0};
                p[FL_C] = b[7];
            end
            CMD_ROL: begin
                r       = {b[6:0], cin};
                p[FL_C] = b[7];
            end
            CMD_SHR: begin
                r       = {1'b0, b[7:1]};
                p[FL_C] = b[0];
            end
            CMD_ROR: begin
                r       = {cin, b[7:1]};
                p[FL_C] = b[0];
            end
            CMD_INC:  r = b + 8'd1;
            CMD_DEC:  r = b - 8'd1;
            CMD_LOAD: r = b;
            default:  wr = 1'b0;
        endcase

        // N/Z from written byte or sub/cmp difference; decimal add and BIT set their own
        if (req.cmd == CMD_SUB) begin
            p[FL_N] = diff[7];
            p[FL_Z] = (diff[7:0] == 8'd0);
        end else if (req.cmd == CMD_CMP) begin
            p[FL_N] = cmp[7];
            p[FL_Z] = (cmp[7:0] == 8'd0);
        end else if (wr && !(req.cmd == CMD_ADD && req.status_in[FL_D])) begin
            p[FL_N] = r[7];
            p[FL_Z] = (r == 8'd0);
        end

        res.result        = r;
        res.status_out    = p;
        res.writes_result = wr;
    end

endmodule

### src/cpu8_alu_with_bcd_flags_core.sv
// Top level: request register, combinational ALU and output register on stream ports.
// Path: a request is registered, then its ALU result loads the output register.
// Throughput: one request per cycle; a waiting output stalls input once both stages fill.
// Depth is set by the request register and the output register around the ALU.
// Reset: synchronous, active low; both stages are emptied, payload is not cleared.
module cpu8_alu_with_bcd_flags_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [3:0] cmd, [11:4] operand_a, [19:12] operand_b, [27:20] status_in, [31:28] zero
    input  logic [c8alu_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] result, [15:8] status_out, [16] writes_result, [23:17] zero
    output logic [c8alu_pkg::M_TDATA_W-1:0]  m_tdata
);
    import c8alu_pkg::*;

    logic     req_valid_reg, req_valid_next;
    alu_req_t req_reg;
    logic     out_valid_reg, out_valid_next;
    alu_res_t out_reg;
    alu_res_t alu_res;
    logic     out_load, req_load;
    alu_req_t req_in;

    assign req_in.cmd       = s_tdata[3:0];
    assign req_in.operand_a = s_tdata[11:4];
    assign req_in.operand_b = s_tdata[19:12];
    assign req_in.status_in = s_tdata[27:20];

    c8alu_exec u_exec (
        .req (req_reg),
        .res (alu_res)
    );

    assign out_load = req_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !req_valid_reg || out_load;
    assign req_load = s_tvalid && s_tready;

    always_comb begin
        req_valid_next = req_valid_reg;
        if (req_load) begin
            req_valid_next = 1'b1;
        end else if (out_load) begin
            req_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req_load) begin
            req_reg <= req_in;
        end
        if (out_load) begin
            out_reg <= alu_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.writes_result, out_reg.status_out, out_reg.result};

endmodule

### src/c8alu_checker.sv
// Port-level checker for the ALU core, bound to the top level.
module c8alu_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [c8alu_pkg::M_TDATA_W-1:0]  m_tdata
);
    import c8alu_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no result straight after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // unwritten byte reads as zero; padding is zero
    a_nowrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[16] || m_tdata[7:0] == 8'd0) && m_tdata[23:17] == 7'd0)
        else $error("bad result byte or padding");

    // with the sink ready, an accepted request passes both stages and shows up as a result
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && m_tready) ##1 m_tready |=> m_tvalid)
        else $error("request lost or late");

endmodule

bind cpu8_alu_with_bcd_flags_core c8alu_checker u_c8alu_checker (.*);

### tb/sv/tb_cpu8_alu_with_bcd_flags_core.sv
// Self-checking testbench for the 8-bit ALU core with packed-decimal add and subtract.
`timescale 1ns / 1ps

module tb_cpu8_alu_with_bcd_flags_core;
    import c8alu_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RAND_REQS   = 1350;
    localparam logic [7:0]  ST_C        = 8'h01;
    localparam logic [7:0]  ST_D        = 8'h08;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    alu_req_t req_q[$];
    int       gap_q[$];
    alu_res_t outcome_q[$];
    alu_req_t tx_req;
    logic     tx_live  = 1'b0;
    alu_res_t want;
    int       rx_hold  = 0;
    bit       rx_calm  = 1'b0;
    int       fails    = 0;
    int       cycles   = 0;

    cpu8_alu_with_bcd_flags_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] nz_set(logic [7:0] p, logic [7:0] v);
        logic [7:0] q;
        q = p;
        q[FL_N] = v[7];
        q[FL_Z] = (v == 8'h00);
        return q;
    endfunction

    function automatic alu_res_t alu_outcome(alu_req_t rq);
        alu_res_t    o;
        logic [7:0]  a, b, p;
        logic        cin, brw;
        logic [8:0]  sum;
        logic [15:0] diff;
        logic [5:0]  lo, hi;
        logic [7:0]  dlo, dhi;
        a = rq.operand_a;
        b = rq.operand_b;
        p = rq.status_in;
        cin = p[FL_C];
        brw = ~cin;
        o.result = 8'h00;
        o.writes_result = 1'b1;
        case (rq.cmd)
            CMD_OR: begin
                o.result = a | b;
                p = nz_set(p, o.result);
            end
            CMD_AND: begin
                o.result = a & b;
                p = nz_set(p, o.result);
            end
            CMD_XOR: begin
                o.result = a ^ b;
                p = nz_set(p, o.result);
            end
            CMD_ADD: begin
                sum = {1'b0, a} + {1'b0, b} + {8'b0, cin};
                if (p[FL_D]) begin
                    lo = {2'b0, a[3:0]} + {2'b0, b[3:0]} + {5'b0, cin};
                    if (lo > 6'd9)
                        lo = lo + 6'd6;
                    hi = {2'b0, a[7:4]} + {2'b0, b[7:4]} + {5'b0, (lo > 6'd15)};
                    // NMOS decimal flags: Z from binary sum, N and V from raw high digit
                    p[FL_Z] = (sum[7:0] == 8'h00);
                    p[FL_N] = (sum[7:0] != 8'h00) && hi[3];
                    p[FL_V] = ~(a[7] ^ b[7]) & (a[7] ^ hi[3]);
                    if (hi > 6'd9)
                        hi = hi + 6'd6;
                    p[FL_C] = (hi > 6'd15);
                    o.result = {hi[3:0], lo[3:0]};
                end else begin
                    p = nz_set(p, sum[7:0]);
                    p[FL_V] = ~(a[7] ^ b[7]) & (a[7] ^ sum[7]);
                    p[FL_C] = sum[8];
                    o.result = sum[7:0];
                end
            end
            CMD_SUB: begin
                diff = {8'b0, a} - {8'b0, b} - {15'b0, brw};
                p = nz_set(p, diff[7:0]);
                p[FL_V] = (a[7] ^ b[7]) & (a[7] ^ diff[7]);
                p[FL_C] = (diff[15:8] == 8'h00);
                if (rq.status_in[FL_D]) begin
                    dlo = {4'b0, a[3:0]} - {4'b0, b[3:0]} - {7'b0, brw};
                    if (dlo[7])
                        dlo = dlo - 8'd6;
                    dhi = {4'b0, a[7:4]} - {4'b0, b[7:4]} - {7'b0, dlo[7]};
                    if (dhi[7])
                        dhi = dhi - 8'd6;
                    o.result = {dhi[3:0], dlo[3:0]};
                end else begin
                    o.result = diff[7:0];
                end
            end
            CMD_CMP: begin
                diff = {8'b0, a} - {8'b0, b};
                p = nz_set(p, diff[7:0]);
                p[FL_C] = (diff[15:8] == 8'h00);
                o.writes_result = 1'b0;
            end
            CMD_BIT: begin
                p[FL_Z] = ((a & b) == 8'h00);
                p[FL_N] = b[7];
                p[FL_V] = b[6];
                o.writes_result = 1'b0;
            end
            CMD_SHL: begin
                o.result = {b[6:0], 1'b0};
                p = nz_set(p, o.result);
                p[FL_C] = b[7];
            end
            CMD_ROL: begin
                o.result = {b[6:0], cin};
                p = nz_set(p, o.result);
                p[FL_C] = b[7];
            end
            CMD_SHR: begin
                o.result = {1'b0, b[7:1]};
                p = nz_set(p, o.result);
                p[FL_C] = b[0];
            end
            CMD_ROR: begin
                o.result = {cin, b[7:1]};
                p = nz_set(p, o.result);
                p[FL_C] = b[0];
            end
            CMD_INC: begin
                o.result = b + 8'd1;
                p = nz_set(p, o.result);
            end
            CMD_DEC: begin
                o.result = b - 8'd1;
                p = nz_set(p, o.result);
            end
            CMD_LOAD: begin
                o.result = b;
                p = nz_set(p, o.result);
            end
            default: begin
                o.writes_result = 1'b0;
            end
        endcase
        o.status_out = p;
        return o;
    endfunction

    // Operand bytes biased towards edges and valid packed-decimal values
    function automatic logic [7:0] pick_byte();
        logic [7:0] v;
        case ($urandom_range(0, 7))
            4: begin
                case ($urandom_range(0, 5))
                    0: v = 8'h00;
                    1: v = 8'hff;
                    2: v = 8'h7f;
                    3: v = 8'h80;
                    4: v = 8'h99;
                    default: v = 8'h01;
                endcase
            end
            5, 6: v = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
            default: v = 8'($urandom);
        endcase
        return v;
    endfunction

    task automatic queue_req(logic [3:0] cmd, logic [7:0] a, logic [7:0] b, logic [7:0] p,
                             int gap);
        alu_req_t rq;
        rq.cmd = cmd;
        rq.operand_a = a;
        rq.operand_b = b;
        rq.status_in = p;
        req_q.push_back(rq);
        gap_q.push_back(gap);
    endtask

    // Request side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            tx_live = s_tvalid;
            if (s_tvalid && s_tready) begin
                outcome_q.push_back(alu_outcome(tx_req));
                tx_live = 1'b0;
            end
            if (!tx_live && req_q.size() > 0) begin
                if (gap_q[0] > 0) begin
                    gap_q[0] = gap_q[0] - 1;
                end else begin
                    tx_req = req_q.pop_front();
                    void'(gap_q.pop_front());
                    s_tdata <= {4'b0, tx_req.status_in, tx_req.operand_b, tx_req.operand_a,
                                tx_req.cmd};
                    tx_live = 1'b1;
                end
            end
            s_tvalid <= tx_live;
        end
    end

    // Result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (outcome_q.size() == 0) begin
                    $error("unexpected result, m_tdata %h", m_tdata);
                    fails++;
                end else begin
                    want = outcome_q.pop_front();
                    if (m_tdata[7:0] !== want.result) begin
                        $error("result: expected %h, got %h", want.result, m_tdata[7:0]);
                        fails++;
                    end
                    if (m_tdata[15:8] !== want.status_out) begin
                        $error("status_out: expected %h, got %h", want.status_out,
                               m_tdata[15:8]);
                        fails++;
                    end
                    if (m_tdata[16] !== want.writes_result) begin
                        $error("writes_result: expected %b, got %b", want.writes_result,
                               m_tdata[16]);
                        fails++;
                    end
                end
                if ($urandom_range(0, 99) < 2)
                    rx_calm = !rx_calm;
                rx_hold = (rx_calm || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
            end
            if (rx_hold > 0) begin
                rx_hold = rx_hold - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus
        bit tx_calm;
        int gap;
        tx_calm = 1'b0;

        queue_req(CMD_OR,   8'h00, 8'h00, 8'hff, 0);
        queue_req(CMD_AND,  8'hff, 8'hff, 8'h00, 0);
        queue_req(CMD_XOR,  8'h55, 8'haa, 8'h34, 3);
        queue_req(CMD_ADD,  8'h7f, 8'h01, 8'h00, 0);
        queue_req(CMD_ADD,  8'hff, 8'h01, 8'h00, 0);
        queue_req(CMD_ADD,  8'h99, 8'h01, ST_D, 1);
        queue_req(CMD_ADD,  8'h50, 8'h50, ST_D, 0);
        queue_req(CMD_ADD,  8'hff, 8'hff, ST_D | ST_C, 0);
        queue_req(CMD_ADD,  8'h00, 8'h00, ST_D, 16);
        queue_req(CMD_ADD,  8'h99, 8'h99, ST_D | ST_C | 8'hf0, 0);
        queue_req(CMD_SUB,  8'h00, 8'h01, ST_C, 0);
        queue_req(CMD_SUB,  8'h80, 8'h01, ST_C, 0);
        queue_req(CMD_SUB,  8'h00, 8'h01, ST_D | ST_C, 2);
        queue_req(CMD_SUB,  8'h10, 8'h01, ST_D, 0);
        queue_req(CMD_SUB,  8'h0f, 8'hfa, ST_D | ST_C, 0);
        queue_req(CMD_CMP,  8'h42, 8'h42, 8'h00, 0);
        queue_req(CMD_CMP,  8'h00, 8'hff, 8'hff, 5);
        queue_req(CMD_BIT,  8'h00, 8'hc0, 8'h00, 0);
        queue_req(CMD_SHL,  8'h00, 8'h80, 8'h00, 0);
        queue_req(CMD_ROL,  8'hff, 8'h80, ST_C, 0);
        queue_req(CMD_SHR,  8'h00, 8'h01, 8'h80, 0);
        queue_req(CMD_ROR,  8'h00, 8'h01, ST_C, 7);
        queue_req(CMD_INC,  8'h00, 8'hff, 8'h00, 0);
        queue_req(CMD_DEC,  8'h00, 8'h00, 8'h00, 0);
        queue_req(CMD_LOAD, 8'hff, 8'h80, 8'h02, 0);

        for (int i = 0; i < RAND_REQS; i++) begin
            if ($urandom_range(0, 99) < 2)
                tx_calm = !tx_calm;
            gap = (tx_calm || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 16);
            queue_req(4'($urandom_range(0, CMD_LOAD)), pick_byte(), pick_byte(),
                      8'($urandom), gap);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (req_q.size() > 0 || s_tvalid || tx_live)
            @(posedge aclk);
        while (outcome_q.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
